FILE: rtl/psf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psf_pkg : shared types, constants and table functions
// Field widths, register codes, controller/datapath command and status
// structs, the minimum-image helper and the cosine table generator.
// ----------------------------------------------------------------------------
package psf_pkg;

   localparam int PosW     = 18;
   localparam int BoxW     = 10;
   localparam int WaveW    = 16;
   localparam int OrderW   = 17;
   localparam int CosW     = 18;
   localparam int DispW    = 20;
   localparam int PhaseW   = 24;
   localparam int QuotW    = 18;
   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 16;

   localparam logic [OrderW-1:0] OrderOne = OrderW'(65536);
   localparam logic [63:0]       HalfPiQ30 = 64'd1686629713;
   localparam logic [63:0]       OneQ30    = 64'd1073741824;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_BOX_WIDTH  = 2'd0,
      CSR_BOX_HEIGHT = 2'd1,
      CSR_WAVE_X     = 2'd2,
      CSR_WAVE_Y     = 2'd3
   } csr_index_type;

   // controller to datapath
   typedef struct packed {
      logic store;      // capture point and write it to the store
      logic rd_en;      // read one stored point for a pair
      logic square;     // register N squared
      logic div_load;   // set up the divider
      logic div_step;   // one quotient bit
      logic out_load;   // load the result register
      logic acc_clear;  // start a new frame sum
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic pipe_busy;
      logic out_free;
   } status_type;

   // minimum-image displacement along one axis, Q11.8
   function automatic logic signed [DispW-1:0] min_image(
      input logic [BoxW-1:0] box,
      input logic [PosW-1:0] a,
      input logic [PosW-1:0] b
   );
      logic [PosW-1:0]         len;
      logic signed [PosW:0]    d1;
      logic signed [PosW:0]    m;
      logic signed [DispW-1:0] m2;
      logic signed [DispW-1:0] res;
      len = {box, 8'b0};
      d1  = $signed({1'b0, a}) - $signed({1'b0, b});
      m   = d1[PosW] ? -d1 : d1;
      m2  = $signed({2'b0, len}) - DispW'(m);
      if (m2 > DispW'(m)) begin
         res = DispW'(d1);
      end else if (d1 > 0) begin
         res = -m2;
      end else if (d1 < 0) begin
         res = m2;
      end else begin
         res = '0;
      end
      return res;
   endfunction

   // next Taylor term: divide the x^2-scaled term by the factorial step (2n-1)(2n)
   function automatic logic [63:0] taylor_term(input logic [63:0] t, input int n);
      logic [63:0] f;
      unique case (n)
         1:       f = t / 64'd2;
         2:       f = t / 64'd12;
         3:       f = t / 64'd30;
         4:       f = t / 64'd56;
         5:       f = t / 64'd90;
         6:       f = t / 64'd132;
         7:       f = t / 64'd182;
         default: f = t / 64'd240;
      endcase
      return f;
   endfunction

   // quarter-wave cosine sample, Q1.16, evaluated at elaboration
   function automatic logic signed [CosW-1:0] quarter_cos(input int j, input int bits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic signed [63:0] s;
      logic [63:0] half_q;
      half_q = 64'(1) << (bits - 3);
      x    = (HalfPiQ30 * 64'(j) + half_q) >> (bits - 2);
      x2   = (x * x) >> 30;
      term = OneQ30;
      s    = $signed(OneQ30);
      for (int n = 1; n <= 8; n++) begin
         term = taylor_term((term * x2) >> 30, n);
         if (n % 2 == 1) begin
            s = s - $signed(term);
         end else begin
            s = s + $signed(term);
         end
      end
      if (s < 0) begin
         s = 0;
      end
      if (s > $signed(OneQ30)) begin
         s = $signed(OneQ30);
      end
      s = (s + 64'sd8192) >>> 14;
      return CosW'(s);
   endfunction

   // full-wave table entry built from four quadrants
   function automatic logic signed [CosW-1:0] cos_entry(input int k, input int bits);
      int q;
      int j;
      int quarter;
      logic signed [CosW-1:0] v;
      quarter = 1 << (bits - 2);
      q = k >> (bits - 2);
      j = k & (quarter - 1);
      unique case (q)
         0:       v = quarter_cos(j, bits);
         1:       v = -quarter_cos(quarter - j, bits);
         2:       v = -quarter_cos(j, bits);
         default: v = quarter_cos(quarter - j, bits);
      endcase
      return v;
   endfunction

endpackage

FILE: rtl/psf_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psf_stream_if : point and result channels
// Valid/ready channels carrying one point of a frame and one frame result.
// ----------------------------------------------------------------------------
interface psf_req_if import psf_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [PosW-1:0] pos_x;
   logic [PosW-1:0] pos_y;
   logic            last_point;

   modport source (output valid, output pos_x, output pos_y, output last_point,
                   input ready);
   modport sink   (input valid, input pos_x, input pos_y, input last_point,
                   output ready);
endinterface

interface psf_rsp_if import psf_pkg::*; #(
   parameter int CountW = 11
) ();
   logic              valid;
   logic              ready;
   logic [OrderW-1:0] order_value;
   logic [CountW-1:0] point_count;

   modport source (output valid, output order_value, output point_count,
                   input ready);
   modport sink   (input valid, input order_value, input point_count,
                   output ready);
endinterface

FILE: rtl/periodic_structure_factor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_structure_factor_unit : positional order parameter of one frame
// Stores 2D points until the last one, sums the cosine of the pair phase
// under the minimum-image rule, and returns (2*sum + N) / N^2 in Q1.16.
//
//   channel  dir  handshake          payload
//   req      in   valid/ready        pos_x, pos_y, last_point
//   rsp      out  valid/ready        order_value, point_count
//   csr      in   csr_wr_en          csr_index, csr_wdata
//
// A point arriving with k points stored is paired with each of them, one
// pair a cycle through the single read port of the point store. Once the
// store is full, further points are accepted and dropped. A last point
// then drains the pipeline, squares N and runs the bit-serial divider.
// Reset is synchronous and clears control state; the store needs none.
// A waiting result does not block points of the next frame until its
// result is ready.
// ----------------------------------------------------------------------------
module periodic_structure_factor_unit import psf_pkg::*; #(
   parameter int MAX_POINTS     = 1024,
   parameter int COS_TABLE_BITS = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   psf_req_if.sink              req,
   psf_rsp_if.source            rsp,
   input  logic                 csr_wr_en,
   input  logic [CsrIdxW-1:0]   csr_index,
   input  logic [CsrDataW-1:0]  csr_wdata
);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int AB = $clog2(MAX_POINTS);

   cmd_type       cmd;
   status_type    status;
   logic [CW-1:0] count;
   logic [AB-1:0] rd_addr;
   logic [CW-1:0] point_count;

   psf_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_last  (req.last_point),
      .req_ready (req.ready),
      .cmd       (cmd),
      .count     (count),
      .rd_addr   (rd_addr),
      .status    (status)
   );

   psf_datapath #(
      .MAX_POINTS     (MAX_POINTS),
      .COS_TABLE_BITS (COS_TABLE_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .pos_x       (req.pos_x),
      .pos_y       (req.pos_y),
      .cmd         (cmd),
      .count       (count),
      .rd_addr     (rd_addr),
      .status      (status),
      .rsp_valid   (rsp.valid),
      .rsp_ready   (rsp.ready),
      .order_value (rsp.order_value),
      .point_count (point_count)
   );

   assign rsp.point_count = point_count;

endmodule

FILE: rtl/psf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psf_ctrl : frame sequencer
// Takes points, walks the stored points for each pair, then drains the
// pair pipeline and steps the divider to close the frame.
// ----------------------------------------------------------------------------
module psf_ctrl import psf_pkg::*; #(
   parameter int MAX_POINTS = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_last,
   output logic                              req_ready,
   output cmd_type                           cmd,
   output logic [$clog2(MAX_POINTS+1)-1:0]   count,
   output logic [$clog2(MAX_POINTS)-1:0]     rd_addr,
   input  status_type                        status
);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int AB = $clog2(MAX_POINTS);
   localparam int SW = $clog2(QuotW);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_PAIR   = 7'b0000010,
      ST_DRAIN  = 7'b0000100,
      ST_SQUARE = 7'b0001000,
      ST_SETUP  = 7'b0010000,
      ST_DIVIDE = 7'b0100000,
      ST_EMIT   = 7'b1000000
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [AB-1:0]   j_ff, j_in;
   logic            last_ff, last_in;
   logic [SW-1:0]   step_ff, step_in;
   logic            full;
   logic [CW-1:0]   count_m1;

   assign full     = (count_ff == CW'(MAX_POINTS));
   assign count_m1 = count_ff - CW'(1);
   assign count    = count_ff;
   assign rd_addr  = j_ff;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      j_in      = j_ff;
      last_in   = last_ff;
      step_in   = step_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               last_in   = req_last;
               cmd.store = !full;
               if (full) begin
                  state_in = req_last ? ST_DRAIN : ST_IDLE;
               end else if (count_ff == '0) begin
                  count_in = CW'(1);
                  state_in = req_last ? ST_DRAIN : ST_IDLE;
               end else begin
                  j_in     = '0;
                  state_in = ST_PAIR;
               end
            end
         end
         ST_PAIR: begin
            cmd.rd_en = 1'b1;
            if (j_ff == count_m1[AB-1:0]) begin
               count_in = count_ff + CW'(1);
               state_in = last_ff ? ST_DRAIN : ST_IDLE;
            end else begin
               j_in = j_ff + AB'(1);
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_SETUP;
         end
         ST_SETUP: begin
            cmd.div_load = 1'b1;
            step_in      = '0;
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (step_ff == SW'(QuotW - 1)) begin
               state_in = ST_EMIT;
            end else begin
               step_in = step_ff + SW'(1);
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.out_load  = 1'b1;
               cmd.acc_clear = 1'b1;
               count_in      = '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         j_ff     <= '0;
         last_ff  <= 1'b0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         j_ff     <= j_in;
         last_ff  <= last_in;
         step_ff  <= step_in;
      end
   end

endmodule

FILE: rtl/psf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psf_datapath : point store, pair pipeline, divider and result register
// Four-stage pair pipeline (read, minimum image, multiply, table), a
// signed frame sum, a bit-per-cycle restoring divider and the output slot.
// ----------------------------------------------------------------------------
module psf_datapath import psf_pkg::*; #(
   parameter int MAX_POINTS     = 1024,
   parameter int COS_TABLE_BITS = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [CsrIdxW-1:0]                csr_index,
   input  logic [CsrDataW-1:0]               csr_wdata,
   input  logic [PosW-1:0]                   pos_x,
   input  logic [PosW-1:0]                   pos_y,
   input  cmd_type                           cmd,
   input  logic [$clog2(MAX_POINTS+1)-1:0]   count,
   input  logic [$clog2(MAX_POINTS)-1:0]     rd_addr,
   output status_type                        status,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [OrderW-1:0]                 order_value,
   output logic [$clog2(MAX_POINTS+1)-1:0]   point_count
);
   localparam int CW        = $clog2(MAX_POINTS + 1);
   localparam int AB        = $clog2(MAX_POINTS);
   localparam int TableSize = 1 << COS_TABLE_BITS;
   localparam int AW        = 2 * CW + CosW;
   localparam int NW        = AW + 2;

   // configuration
   logic [BoxW-1:0]  box_w_ff, box_h_ff;
   logic [WaveW-1:0] wave_x_ff, wave_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_w_ff  <= BoxW'(100);
         box_h_ff  <= BoxW'(100);
         wave_x_ff <= WaveW'(8192);
         wave_y_ff <= WaveW'(14189);
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_BOX_WIDTH:  box_w_ff  <= csr_wdata[BoxW-1:0];
            CSR_BOX_HEIGHT: box_h_ff  <= csr_wdata[BoxW-1:0];
            CSR_WAVE_X:     wave_x_ff <= csr_wdata[WaveW-1:0];
            CSR_WAVE_Y:     wave_y_ff <= csr_wdata[WaveW-1:0];
            default:        box_w_ff  <= box_w_ff;
         endcase
      end
   end

   // point store and current point
   logic [PosW-1:0] x_mem [MAX_POINTS];
   logic [PosW-1:0] y_mem [MAX_POINTS];
   logic [PosW-1:0] cur_x_ff, cur_y_ff;

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         x_mem[count[AB-1:0]] <= pos_x;
         y_mem[count[AB-1:0]] <= pos_y;
         cur_x_ff <= pos_x;
         cur_y_ff <= pos_y;
      end
   end

   // stage 1: stored point read
   logic [PosW-1:0] s1_x_ff, s1_y_ff;
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         s1_x_ff <= x_mem[rd_addr];
         s1_y_ff <= y_mem[rd_addr];
      end
   end

   // stage 2: minimum-image displacement
   logic signed [DispW-1:0] s2_dx_ff, s2_dy_ff;
   always_ff @(posedge clock) begin
      s2_dx_ff <= min_image(box_w_ff, cur_x_ff, s1_x_ff);
      s2_dy_ff <= min_image(box_h_ff, cur_y_ff, s1_y_ff);
   end

   // stage 3: phase products, modulo one turn
   logic [PhaseW-1:0] s3_px_ff, s3_py_ff;
   logic [PhaseW-1:0] dx_ext, dy_ext;
   assign dx_ext = PhaseW'(s2_dx_ff);
   assign dy_ext = PhaseW'(s2_dy_ff);
   always_ff @(posedge clock) begin
      s3_px_ff <= PhaseW'(PhaseW'(wave_x_ff) * dx_ext);
      s3_py_ff <= PhaseW'(PhaseW'(wave_y_ff) * dy_ext);
   end

   // stage 4: cosine table lookup
   logic signed [CosW-1:0] cos_rom [TableSize];
   for (genvar k = 0; k < TableSize; k++) begin : g_rom
      assign cos_rom[k] = cos_entry(k, COS_TABLE_BITS);
   end

   logic [PhaseW-1:0]          phase;
   logic [COS_TABLE_BITS-1:0]  tab_idx;
   logic signed [CosW-1:0]     s4_cos_ff;
   assign phase   = s3_px_ff + s3_py_ff;
   assign tab_idx = phase[PhaseW-1 -: COS_TABLE_BITS];
   always_ff @(posedge clock) begin
      s4_cos_ff <= cos_rom[tab_idx];
   end

   // pipeline valid flags
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.rd_en;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // frame sum of pair cosines
   logic signed [AW-1:0] acc_ff;
   always_ff @(posedge clock) begin
      if (reset || cmd.acc_clear) begin
         acc_ff <= '0;
      end else if (v4_ff) begin
         acc_ff <= acc_ff + AW'(s4_cos_ff);
      end
   end

   // N squared
   logic [2*CW-1:0] nsq_ff;
   always_ff @(posedge clock) begin
      if (cmd.square) begin
         nsq_ff <= count * count;
      end
   end

   // restoring divider, one quotient bit a cycle
   logic signed [NW-1:0] num;
   logic [NW-1:0]        rem_ff, dsr_ff;
   logic [QuotW-1:0]     quot_ff;
   logic                 take;
   assign num  = (NW'(acc_ff) <<< 1) + $signed(NW'({count, 16'b0}));
   assign take = (rem_ff >= dsr_ff);

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         rem_ff  <= (num > 0) ? (NW'(num) + NW'(nsq_ff >> 1)) : '0;
         dsr_ff  <= NW'(nsq_ff) << (QuotW - 1);
         quot_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= take ? (rem_ff - dsr_ff) : rem_ff;
         dsr_ff  <= dsr_ff >> 1;
         quot_ff <= {quot_ff[QuotW-2:0], take};
      end
   end

   // result slot
   logic              rsp_valid_ff;
   logic [OrderW-1:0] order_ff;
   logic [CW-1:0]     pcount_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         order_ff  <= (quot_ff > QuotW'(OrderOne)) ? OrderOne : quot_ff[OrderW-1:0];
         pcount_ff <= count;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign order_value      = order_ff;
   assign point_count      = pcount_ff;
   assign status.pipe_busy = v1_ff | v2_ff | v3_ff | v4_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

endmodule

FILE: rtl/psf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psf_checker : port-level checks
// Watches the result channel of the top level and is bound to it.
// ----------------------------------------------------------------------------
module psf_checker import psf_pkg::*; #(
   parameter int CountW = 11
) (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [OrderW-1:0] order_value,
   input logic [CountW-1:0] point_count
);
   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(order_value)
         && $stable(point_count))
      else $error("result changed while stalled");

   // order value saturates at one
   a_order_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> order_value <= OrderOne)
      else $error("order value above one");

   // a frame always holds a point
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> point_count != '0)
      else $error("empty frame result");

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind periodic_structure_factor_unit psf_checker #(.CountW($clog2(MAX_POINTS + 1))) u_psf_chk (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .order_value (rsp.order_value),
   .point_count (rsp.point_count)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench : order parameter unit, self-checking test
// Streams frames of 2D points into the unit under several box and wave
// settings and idling mixes. A scoreboard predicts each frame's order value
// and point count and compares them with every result transfer.
// ----------------------------------------------------------------------------
module testbench;
   import psf_pkg::*;

   localparam int FrameCap  = 1024;
   localparam int StallLim  = 20000;

   // order value prediction and result checking
   class frame_scoreboard;
      int                 cos_lut[FrameCap];
      logic [PosW-1:0]    xs[$];
      logic [PosW-1:0]    ys[$];
      longint             cos_sum;
      logic [OrderW-1:0]  exp_order[$];
      logic [10:0]        exp_count[$];
      logic [BoxW-1:0]    box_w;
      logic [BoxW-1:0]    box_h;
      logic [WaveW-1:0]   wave_x;
      logic [WaveW-1:0]   wave_y;
      int                 fails;

      function new();
         for (int k = 0; k < FrameCap; k++) begin
            case (k >> 8)
               0:       cos_lut[k] = quarter_sample(k % 256);
               1:       cos_lut[k] = -quarter_sample(256 - k % 256);
               2:       cos_lut[k] = -quarter_sample(k % 256);
               default: cos_lut[k] = quarter_sample(256 - k % 256);
            endcase
         end
         box_w = 100; box_h = 100; wave_x = 8192; wave_y = 14189;
         cos_sum = 0;
         fails = 0;
      endfunction

      // Taylor series cosine over one quadrant, Q1.16
      function int quarter_sample(int j);
         longint unsigned ang, ang2, term;
         longint acc;
         ang  = (64'd1686629713 * longint'(j) + 128) / 256;
         ang2 = (ang * ang) >> 30;
         term = 64'd1 << 30;
         acc  = longint'(1) << 30;
         for (int n = 1; n <= 8; n++) begin
            term = ((term * ang2) >> 30) / longint'((2 * n - 1) * (2 * n));
            if (n % 2 == 1) acc = acc - longint'(term);
            else acc = acc + longint'(term);
         end
         if (acc < 0) acc = 0;
         if (acc > (longint'(1) << 30)) acc = longint'(1) << 30;
         return int'((acc + 8192) >>> 14);
      endfunction

      function longint wrap_disp(logic [BoxW-1:0] box, logic [PosW-1:0] a,
                                 logic [PosW-1:0] b);
         longint span, d1, m, m2;
         span = longint'(box) << 8;
         d1   = longint'(a) - longint'(b);
         m    = d1 < 0 ? -d1 : d1;
         m2   = span - m;
         if (m2 > m) return d1;
         if (d1 > 0) return -m2;
         if (d1 < 0) return m2;
         return 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [CsrDataW-1:0] val);
         case (idx)
            CSR_BOX_WIDTH:  box_w  = val[BoxW-1:0];
            CSR_BOX_HEIGHT: box_h  = val[BoxW-1:0];
            CSR_WAVE_X:     wave_x = val;
            CSR_WAVE_Y:     wave_y = val;
         endcase
      endfunction

      function int pending();
         return exp_order.size();
      endfunction

      // fold one accepted point into the frame sum
      function void note_point(logic [PosW-1:0] px, logic [PosW-1:0] py, logic last);
         longint ph, n, nsq, num, val;
         if (xs.size() < FrameCap) begin
            foreach (xs[j]) begin
               ph = longint'(wave_x) * wrap_disp(box_w, px, xs[j])
                  + longint'(wave_y) * wrap_disp(box_h, py, ys[j]);
               cos_sum += cos_lut[ph[23:14]];
            end
            xs.push_back(px);
            ys.push_back(py);
         end
         if (last) begin
            n   = xs.size();
            nsq = n * n;
            num = 2 * cos_sum + n * 65536;
            val = 0;
            if (num > 0 && nsq > 0) begin
               val = (num + nsq / 2) / nsq;
               if (val > 65536) val = 65536;
            end
            exp_order.push_back(val[OrderW-1:0]);
            exp_count.push_back(n[10:0]);
            xs.delete();
            ys.delete();
            cos_sum = 0;
         end
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         fails++;
      endtask

      task check_result(logic [OrderW-1:0] order, logic [10:0] count);
         logic [OrderW-1:0] eo;
         logic [10:0]       ec;
         if (exp_order.size() == 0) begin
            report($sformatf("unexpected result order=%0d count=%0d", order, count));
         end else begin
            eo = exp_order.pop_front();
            ec = exp_count.pop_front();
            if (order !== eo)
               report($sformatf("order_value %0d, expected %0d", order, eo));
            if (count !== ec)
               report($sformatf("point_count %0d, expected %0d", count, ec));
         end
      endtask
   endclass

   logic clock;
   logic reset;
   logic                csr_wr_en;
   logic [CsrIdxW-1:0]  csr_index;
   logic [CsrDataW-1:0] csr_wdata;
   int                  send_idle_pct;
   int                  rsp_stall_pct;
   int                  quiet_cycles;
   frame_scoreboard     sb;

   psf_req_if                  req_ch ();
   psf_rsp_if #(.CountW(11))   rsp_ch ();

   periodic_structure_factor_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // drain results with random stalls, check each transfer, watch for hangs
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.order_value, rsp_ch.point_count);
         if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= StallLim) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // offer one point, hold it until the transfer
   task send_point(logic [PosW-1:0] px, logic [PosW-1:0] py, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.pos_x      <= px;
      req_ch.pos_y      <= py;
      req_ch.last_point <= last;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      sb.note_point(px, py, last);
   endtask

   // hold off until every frame result is back and the unit has settled
   task wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
   endtask

   task write_reg(csr_index_type idx, logic [CsrDataW-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      sb.set_reg(idx, val);
   endtask

   task write_all(logic [9:0] bw, logic [9:0] bh, logic [15:0] wx, logic [15:0] wy);
      wait_drained();
      write_reg(CSR_BOX_WIDTH, CsrDataW'(bw));
      write_reg(CSR_BOX_HEIGHT, CsrDataW'(bh));
      write_reg(CSR_WAVE_X, wx);
      write_reg(CSR_WAVE_Y, wy);
   endtask

   function logic [PosW-1:0] pick_pos(logic [9:0] box);
      int span;
      span = int'(box) << 8;
      case ($urandom_range(3))
         0:       return PosW'($urandom);
         1:       return PosW'((int'($urandom_range(7)) * 64) % (span + 1));
         default: return PosW'($urandom_range(span == 0 ? 0 : span - 1));
      endcase
   endfunction

   // random frames, mostly short
   task random_frames(int points);
      int len;
      while (points > 0) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
         for (int i = 0; i < len; i++)
            send_point(pick_pos(sb.box_w), pick_pos(sb.box_h), i == len - 1);
         points -= len;
      end
   endtask

   initial begin
      sb = new();
      reset            <= 1'b1;
      csr_wr_en        <= 1'b0;
      csr_index        <= CSR_BOX_WIDTH;
      csr_wdata        <= '0;
      req_ch.valid      <= 1'b0;
      req_ch.pos_x      <= '0;
      req_ch.pos_y      <= '0;
      req_ch.last_point <= 1'b0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed frames at reset settings
      send_point('0, '0, 1'b1);
      send_point(18'd1000, 18'd2000, 1'b0);
      send_point(18'd1000, 18'd2000, 1'b1);
      send_point('1, '1, 1'b0);
      send_point('0, '0, 1'b0);
      send_point(18'h2AAAA, 18'h15555, 1'b1);
      send_point(18'd25599, 18'd0, 1'b0);
      send_point(18'd0, 18'd25599, 1'b0);
      send_point(18'd12800, 18'd12800, 1'b0);
      send_point(18'd12801, 18'd12799, 1'b1);
      write_all(10'd1, 10'd1023, 16'hFFFF, 16'd0);
      send_point('1, 18'd0, 1'b0);
      send_point(18'd0, '1, 1'b0);
      send_point(18'd128, 18'd200000, 1'b1);
      write_all(10'd0, 10'd0, 16'd0, 16'hFFFF);
      send_point(18'd300, 18'd77, 1'b0);
      send_point(18'd5, 18'd262000, 1'b0);
      send_point(18'd0, 18'd0, 1'b1);
      write_all(10'd1023, 10'd1, 16'd1, 16'd32768);
      send_point('1, '1, 1'b0);
      send_point(18'd0, 18'd131072, 1'b1);

      // full frame: points past the cap are dropped, last still closes it
      write_all(10'd64, 10'd64, 16'd1024, 16'd2048);
      for (int i = 0; i < FrameCap + 6; i++)
         send_point(pick_pos(10'd64), pick_pos(10'd64), i == FrameCap + 5);

      // random phases under varied settings and idling
      write_all(10'd100, 10'd100, 16'd8192, 16'd14189);
      random_frames(160);
      send_idle_pct = 57;
      write_all(10'($urandom_range(1, 1023)), 10'($urandom_range(1, 1023)),
                16'($urandom), 16'($urandom));
      random_frames(160);
      send_idle_pct = 0;
      rsp_stall_pct = 57;
      write_all(10'd1023, 10'd1023, 16'hFFFF, 16'hFFFF);
      random_frames(160);
      send_idle_pct = 29;
      rsp_stall_pct = 29;
      write_all(10'($urandom_range(1, 40)), 10'($urandom_range(1, 40)),
                16'($urandom), 16'($urandom));
      random_frames(160);

      wait_drained();
      if (sb.fails == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

FILE: sim.f
rtl/psf_pkg.sv
rtl/psf_stream_if.sv
rtl/psf_ctrl.sv
rtl/psf_datapath.sv
rtl/periodic_structure_factor_unit.sv
rtl/psf_checker.sv
tb/testbench.sv
